[sv/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task tick dispatcher package
// Request, result and task slot types, operation and status codes, and the
// per-slot tick update used by the top level.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_SUSPEND = 3'd3;
  localparam logic [2:0] OP_RESUME  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TAKEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic KIND_ACK      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } ptd_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [15:0] period;
    logic [15:0] first_delay;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] task_index;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic        present;
    logic        resumed;
    logic [15:0] period;
    logic [15:0] countdown;
  } task_slot_t;

  // Control handed from the sequencer to every cell.
  typedef struct packed {
    logic        shift;
    logic [2:0]  func;
    logic [15:0] period;
    logic [15:0] first_delay;
  } cell_cmd_t;

  function automatic logic slot_fires(task_slot_t s);
    return s.resumed && s.present && (s.countdown == 16'd0);
  endfunction

  // State of one slot after a tick has passed over it.
  function automatic task_slot_t tick_slot(task_slot_t s);
    task_slot_t r;
    r = s;
    if (s.resumed) begin
      if (s.countdown == 16'd0) begin
        if (s.present) begin
          r.countdown = s.period - 16'd1;
        end
      end else begin
        r.countdown = s.countdown - 16'd1;
      end
    end
    return r;
  endfunction

endpackage

[sv/ptd_cell.sv]
// ----------------------------------------------------------------------------
// Task slot cell
// Holds one task slot. At rest it applies commands addressed to it; during a
// tick scan it loads the slot state handed over by its neighbor.
// ----------------------------------------------------------------------------
module ptd_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  ptd_pkg::cell_cmd_t     cmd,
  input  logic                   sel,
  input  ptd_pkg::task_slot_t    shift_in,
  output ptd_pkg::task_slot_t    slot_state
);
  import ptd_pkg::*;

  task_slot_t slot_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_reg <= '0;
    end else if (cmd.shift) begin
      slot_reg <= shift_in;
    end else if (sel) begin
      case (cmd.func)
        OP_CREATE: begin
          if (!slot_reg.present) begin
            slot_reg.present   <= 1'b1;
            slot_reg.resumed   <= 1'b1;
            slot_reg.period    <= cmd.period;
            slot_reg.countdown <= cmd.first_delay;
          end
        end
        OP_DELETE:  slot_reg.present <= 1'b0;
        OP_SUSPEND: slot_reg.resumed <= 1'b0;
        OP_RESUME:  slot_reg.resumed <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign slot_state = slot_reg;

endmodule

[sv/periodic_task_tick_dispatcher_top.sv]
// ----------------------------------------------------------------------------
// Periodic task tick dispatcher
// A ring of task slot cells. Commands update the addressed cell in place; a
// tick rotates the ring once, updating the slot that passes the head.
// ----------------------------------------------------------------------------
// Commands: acknowledged in the cycle after acceptance, one command per cycle
// while idle. Tick: busy in the scan and flush states; the ring moves one slot
// per cycle past the single update point. Each dispatch appears in the cycle
// after the next firing slot is found, the final one in the cycle after flush.
// Reset clears every slot and all control state. Results cannot be stalled.
module periodic_task_tick_dispatcher_top #(
  parameter int TASK_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptd_pkg::req_t request,
  output logic          result_valid,
  output ptd_pkg::res_t result
);
  import ptd_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TASK_SLOTS - 1);

  ptd_state_t       state, state_next;
  logic [IDX_W-1:0] step, step_next;
  logic             pend_valid, pend_valid_next;
  logic [IDX_W-1:0] pend_index, pend_index_next;
  logic             result_valid_next;
  res_t             result_next;

  cell_cmd_t             cmd;
  task_slot_t            cells [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] sel;
  logic [TASK_SLOTS-1:0] present_vec;
  task_slot_t            head_next;
  logic                  head_fire;
  logic                  accept;
  logic                  is_cmd;
  logic                  in_range;

  assign accept   = start && !busy;
  assign is_cmd   = (request.func inside {OP_CREATE, OP_DELETE, OP_SUSPEND, OP_RESUME});
  assign in_range = request.slot < 8'(TASK_SLOTS);

  assign head_next = tick_slot(cells[0]);
  assign head_fire = slot_fires(cells[0]);

  always_comb begin
    cmd.shift       = (state == S_SCAN);
    cmd.func        = request.func;
    cmd.period      = request.period;
    cmd.first_delay = request.first_delay;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
      assign sel[gi]         = accept && is_cmd && (request.slot == 8'(gi));
      assign present_vec[gi] = cells[gi].present;
      if (gi == TASK_SLOTS - 1) begin : g_tail
        ptd_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmd        (cmd),
          .sel        (sel[gi]),
          .shift_in   (head_next),
          .slot_state (cells[gi])
        );
      end else begin : g_body
        ptd_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmd        (cmd),
          .sel        (sel[gi]),
          .shift_in   (cells[gi+1]),
          .slot_state (cells[gi])
        );
      end
    end
  endgenerate

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && request.func == OP_TICK) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step == LAST_STEP) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath control. A found dispatch is held back until the
  // next one is found, so that the final one can carry the last mark.
  always_comb begin
    busy              = (state != S_IDLE);
    step_next         = '0;
    pend_valid_next   = pend_valid;
    pend_index_next   = pend_index;
    result_valid_next = 1'b0;
    result_next       = '0;
    case (state)
      S_IDLE: begin
        pend_valid_next = 1'b0;
        if (start && is_cmd) begin
          result_valid_next = 1'b1;
          result_next.kind  = KIND_ACK;
          result_next.last  = 1'b1;
          if (!in_range) begin
            result_next.status = ST_RANGE;
          end else if (request.func == OP_CREATE
                       && present_vec[request.slot[IDX_W-1:0]]) begin
            result_next.status = ST_TAKEN;
          end else begin
            result_next.status = ST_OK;
          end
        end
      end
      S_SCAN: begin
        step_next = step + 1'b1;
        if (head_fire) begin
          pend_valid_next = 1'b1;
          pend_index_next = step;
          if (pend_valid) begin
            result_valid_next      = 1'b1;
            result_next.kind       = KIND_DISPATCH;
            result_next.task_index = 6'(pend_index);
            result_next.status     = ST_OK;
            result_next.last       = 1'b0;
          end
        end
      end
      S_FLUSH: begin
        pend_valid_next = 1'b0;
        if (pend_valid) begin
          result_valid_next      = 1'b1;
          result_next.kind       = KIND_DISPATCH;
          result_next.task_index = 6'(pend_index);
          result_next.status     = ST_OK;
          result_next.last       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_index <= pend_index_next;
    result     <= result_next;
  end

`ifndef SYNTHESIS
  a_cmd_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.func == OP_CREATE || request.func == OP_DELETE
      || request.func == OP_SUSPEND || request.func == OP_RESUME))
    |=> (result_valid && result.kind == KIND_ACK && result.last))
    else $error("command request not acknowledged in the next cycle");

  a_dispatch_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_DISPATCH) |-> (result.status == ST_OK))
    else $error("dispatch carries a nonzero status");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> (state == S_IDLE))
    else $error("flush cycle not followed by idle");

  a_mid_dispatch: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_DISPATCH && !result.last)
    |-> (state == S_SCAN || state == S_FLUSH))
    else $error("non-final dispatch outside a tick scan");
`endif

endmodule
